[hdl/ocl_pkg.sv]
`timescale 1ns / 1ps
package ocl_pkg;

  localparam logic [2:0] CODE_CUTOFF  = 3'd0;
  localparam logic [2:0] CODE_LEFT    = 3'd1;
  localparam logic [2:0] CODE_RIGHT   = 3'd2;
  localparam logic [2:0] CODE_COLLIDE = 3'd3;
  localparam logic [2:0] CODE_DEGEN   = 3'd4;

  localparam logic [0:0] REG_INV_TH = 1'b0;
  localparam logic [0:0] REG_INV_TS = 1'b1;

  localparam logic [30:0] INV_RESET = 31'd65536;

  typedef struct packed {
    logic signed [31:0] own_pos_x;
    logic signed [31:0] own_pos_y;
    logic signed [31:0] own_vel_x;
    logic signed [31:0] own_vel_y;
    logic        [30:0] own_reach;
    logic signed [31:0] nbr_pos_x;
    logic signed [31:0] nbr_pos_y;
    logic signed [31:0] nbr_vel_x;
    logic signed [31:0] nbr_vel_y;
    logic        [30:0] nbr_reach;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] rpx;
    logic signed [31:0] rpy;
    logic signed [31:0] rvx;
    logic signed [31:0] rvy;
    logic signed [31:0] ovx;
    logic signed [31:0] ovy;
    logic        [31:0] comb;
    logic        [62:0] distsq;
    logic        [63:0] combsq;
    logic               apart;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] r;
  } sq_t;

  typedef struct packed {
    logic [63:0] r;
    logic [15:0] q;
  } dv_t;

  function automatic logic signed [31:0] sat_sym(input logic signed [47:0] x);
    if (x > 48'sd2147483647) begin
      return 32'sd2147483647;
    end else if (x < -48'sd2147483647) begin
      return -32'sd2147483647;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
    if (x > 52'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -52'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic sq_t sq_step(input sq_t a, input logic [63:0] b);
    sq_t o;
    o = a;
    if (a.n >= a.r + b) begin
      o.n = a.n - (a.r + b);
      o.r = (a.r >> 1) + b;
    end else begin
      o.r = a.r >> 1;
    end
    return o;
  endfunction

  function automatic dv_t dv_step(input dv_t a, input logic [62:0] den);
    dv_t o;
    logic [63:0] t;
    logic ge;
    t = {a.r[62:0], 1'b0};
    ge = (t >= {1'b0, den});
    o.q = {a.q[14:0], ge};
    o.r = ge ? t - {1'b0, den} : t;
    return o;
  endfunction

endpackage

[hdl/orca_constraint_line.sv]
`timescale 1ns / 1ps
// ORCA half-plane constraint for one agent/neighbor pair per word. A pair is
// taken every cycle while the queue has room, even while the back stalls.
// Its line passes three front registers (relative state, squares, overlap
// classification), the queue, then a 29-stage back pipeline whose length is
// set by the integer square root (four result bits a stage) and the Q1.16
// divider (four quotient bits a stage). The back pipeline stalls as a whole
// when the output word is not taken. The user must write registers through
// cfg_we / cfg_index / cfg_data only while idle; the block does not check it.
module orca_constraint_line #(
  parameter int FIFO_DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [30:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // own_pos_x, own_pos_y, own_vel_x, own_vel_y, own_reach,
  // nbr_pos_x, nbr_pos_y, nbr_vel_x, nbr_vel_y, nbr_reach, zero pad
  input  logic [319:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // dir_x, dir_y, point_x, point_y, zero pad
  output logic [103:0] m_tdata,
  // case_code
  output logic [2:0]   m_tuser
);
  import ocl_pkg::*;

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [30:0] inv_th;
  logic [30:0] inv_ts;
  pair_t pair;
  push_t push;
  item_t head;
  logic head_valid;
  logic pop;
  logic [CW-1:0] fifo_count;
  logic signed [17:0] dir_x;
  logic signed [17:0] dir_y;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [2:0] case_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_th <= INV_RESET;
      inv_ts <= INV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INV_TH: inv_th <= cfg_data;
        REG_INV_TS: inv_ts <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pair.own_pos_x = s_tdata[31:0];
  assign pair.own_pos_y = s_tdata[63:32];
  assign pair.own_vel_x = s_tdata[95:64];
  assign pair.own_vel_y = s_tdata[127:96];
  assign pair.own_reach = s_tdata[158:128];
  assign pair.nbr_pos_x = s_tdata[190:159];
  assign pair.nbr_pos_y = s_tdata[222:191];
  assign pair.nbr_vel_x = s_tdata[254:223];
  assign pair.nbr_vel_y = s_tdata[286:255];
  assign pair.nbr_reach = s_tdata[317:287];

  ocl_front #(.DEPTH(FIFO_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .pair     (pair),
    .count    (fifo_count),
    .push     (push)
  );

  ocl_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .count      (fifo_count)
  );

  ocl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .inv_th     (inv_th),
    .inv_ts     (inv_ts),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .point_x    (point_x),
    .point_y    (point_y),
    .case_code  (case_code)
  );

  assign m_tdata = {4'd0, point_y, point_x, dir_y, dir_x};
  assign m_tuser = case_code;

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= CW'(FIFO_DEPTH))
    else $error("queue count beyond depth");
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == CODE_DEGEN) |-> (m_tdata[35:0] == 36'd0))
    else $error("degenerate line with nonzero direction");
  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (dir_x <= 18'sd65536 && dir_x >= -18'sd65536
               && dir_y <= 18'sd65536 && dir_y >= -18'sd65536))
    else $error("direction outside unit range");
`endif

endmodule

[hdl/ocl_fifo.sv]
`timescale 1ns / 1ps
module ocl_fifo #(
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ocl_pkg::push_t             push,
  input  logic                       pop,
  output ocl_pkg::item_t             head,
  output logic                       head_valid,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import ocl_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wptr] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push.valid) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(push.valid) - CW'(pop);
    end
  end

  assign head       = mem[rptr];
  assign head_valid = (count != '0);

endmodule

[hdl/ocl_front.sv]
`timescale 1ns / 1ps
module ocl_front #(
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ocl_pkg::pair_t             pair,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  output ocl_pkg::push_t             push
);
  import ocl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [2:0] vld;
  item_t f1;
  item_t f2;
  item_t f2_next;
  item_t f3;
  item_t f3_next;
  logic [61:0] sqx;
  logic [61:0] sqy;
  logic [CW:0] total;

  assign total = {1'b0, count} + (CW+1)'(vld[0]) + (CW+1)'(vld[1]) + (CW+1)'(vld[2]);
  assign in_ready = (total < (CW+1)'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], in_valid & in_ready};
    end
  end

  // relative state
  always_ff @(posedge clk) begin
    f1.rpx    <= sat_sym(48'(pair.nbr_pos_x) - 48'(pair.own_pos_x));
    f1.rpy    <= sat_sym(48'(pair.nbr_pos_y) - 48'(pair.own_pos_y));
    f1.rvx    <= sat_sym(48'(pair.own_vel_x) - 48'(pair.nbr_vel_x));
    f1.rvy    <= sat_sym(48'(pair.own_vel_y) - 48'(pair.nbr_vel_y));
    f1.ovx    <= pair.own_vel_x;
    f1.ovy    <= pair.own_vel_y;
    f1.comb   <= {1'b0, pair.own_reach} + {1'b0, pair.nbr_reach};
    f1.distsq <= '0;
    f1.combsq <= '0;
    f1.apart  <= 1'b0;
  end

  // squares
  always_comb begin
    f2_next        = f1;
    f2_next.combsq = 64'(f1.comb) * 64'(f1.comb);
  end

  always_ff @(posedge clk) begin
    f2  <= f2_next;
    sqx <= 62'(64'(f1.rpx) * 64'(f1.rpx));
    sqy <= 62'(64'(f1.rpy) * 64'(f1.rpy));
  end

  // classify apart / overlapping
  always_comb begin
    f3_next        = f2;
    f3_next.distsq = {1'b0, sqx} + {1'b0, sqy};
    f3_next.apart  = ({2'b0, sqx} + {2'b0, sqy}) > f2.combsq;
  end

  always_ff @(posedge clk) begin
    f3 <= f3_next;
  end

  assign push = {vld[2], f3};

endmodule

[hdl/ocl_back.sv]
`timescale 1ns / 1ps
module ocl_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [30:0]        inv_th,
  input  logic [30:0]        inv_ts,
  input  ocl_pkg::item_t     head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] dir_x,
  output logic signed [17:0] dir_y,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic [2:0]         case_code
);
  import ocl_pkg::*;

  localparam int ST_PROD = 1;
  localparam int ST_W    = 2;
  localparam int ST_MUL  = 3;
  localparam int ST_SUM  = 4;
  localparam int ST_MAG  = 5;
  localparam int ST_PART = 6;
  localparam int ST_WIDE = 7;
  localparam int ST_SEL  = 8;
  localparam int ST_SQ0  = 9;
  localparam int SQ_STG  = 8;
  localparam int SQ_PER  = 4;
  localparam int ST_NUM  = ST_SQ0 + SQ_STG;
  localparam int ST_ARG  = ST_NUM + 1;
  localparam int ST_DV0  = ST_ARG + 1;
  localparam int DV_STG  = 4;
  localparam int DV_PER  = 4;
  localparam int ST_DIR  = ST_DV0 + DV_STG;
  localparam int ST_P1   = ST_DIR + 1;
  localparam int ST_P2   = ST_P1 + 1;
  localparam int ST_P3   = ST_P2 + 1;
  localparam int ST_P4   = ST_P3 + 1;
  localparam int ST_OUT  = ST_P4 + 1;
  localparam int NST     = ST_OUT + 1;

  typedef struct packed {
    item_t               it;
    logic        [30:0]  inv;
    logic signed [62:0]  prx;
    logic signed [62:0]  pry;
    logic signed [31:0]  wx;
    logic signed [31:0]  wy;
    logic signed [63:0]  mdx;
    logic signed [63:0]  mdy;
    logic signed [63:0]  mwx;
    logic signed [63:0]  mwy;
    logic signed [63:0]  mtx;
    logic signed [63:0]  mty;
    logic signed [63:0]  dot1;
    logic        [62:0]  wls;
    logic signed [63:0]  det;
    logic        [63:0]  amag;
    logic                dneg;
    logic        [63:0]  a_ll;
    logic        [63:0]  a_lh;
    logic        [63:0]  a_hh;
    logic        [63:0]  c_ll;
    logic        [63:0]  c_lh;
    logic        [63:0]  c_hl;
    logic        [63:0]  c_hh;
    logic        [127:0] asq;
    logic        [127:0] cw;
    logic                circ;
    logic        [2:0]   code;
    sq_t                 sq;
    logic signed [64:0]  pa;
    logic signed [64:0]  pb;
    logic signed [64:0]  pc;
    logic signed [64:0]  pd;
    logic        [62:0]  pinv;
    logic signed [48:0]  s;
    logic        [62:0]  den;
    logic        [65:0]  magx;
    logic        [65:0]  magy;
    logic                sgx;
    logic                sgy;
    logic                bigx;
    logic                bigy;
    dv_t                 dvx;
    dv_t                 dvy;
    logic signed [17:0]  dx;
    logic signed [17:0]  dy;
    logic signed [17:0]  nxq;
    logic signed [17:0]  nyq;
    logic signed [66:0]  px;
    logic signed [66:0]  py;
    logic signed [35:0]  dot2;
    logic signed [53:0]  mx;
    logic signed [53:0]  my;
    logic signed [50:0]  ux;
    logic signed [50:0]  uy;
    logic signed [31:0]  ptx;
    logic signed [31:0]  pty;
  } bk_t;

  bk_t st  [NST];
  bk_t nxt [NST];
  logic [NST-1:0] vld;
  logic ce;

  assign ce  = !vld[NST-1] || out_ready;
  assign pop = ce && head_valid;

  always_comb begin
    nxt[0]     = st[0];
    nxt[0].it  = head;
    nxt[0].inv = head.apart ? inv_th : inv_ts;
  end

  always_comb begin
    nxt[ST_PROD]     = st[ST_PROD-1];
    nxt[ST_PROD].prx = 63'(st[ST_PROD-1].it.rpx) * $signed({32'd0, st[ST_PROD-1].inv});
    nxt[ST_PROD].pry = 63'(st[ST_PROD-1].it.rpy) * $signed({32'd0, st[ST_PROD-1].inv});
  end

  always_comb begin
    nxt[ST_W]    = st[ST_W-1];
    nxt[ST_W].wx = sat_sym(48'(st[ST_W-1].it.rvx) - 48'(st[ST_W-1].prx >>> 16));
    nxt[ST_W].wy = sat_sym(48'(st[ST_W-1].it.rvy) - 48'(st[ST_W-1].pry >>> 16));
  end

  always_comb begin
    nxt[ST_MUL]     = st[ST_MUL-1];
    nxt[ST_MUL].mdx = 64'(st[ST_MUL-1].wx) * 64'(st[ST_MUL-1].it.rpx);
    nxt[ST_MUL].mdy = 64'(st[ST_MUL-1].wy) * 64'(st[ST_MUL-1].it.rpy);
    nxt[ST_MUL].mwx = 64'(st[ST_MUL-1].wx) * 64'(st[ST_MUL-1].wx);
    nxt[ST_MUL].mwy = 64'(st[ST_MUL-1].wy) * 64'(st[ST_MUL-1].wy);
    nxt[ST_MUL].mtx = 64'(st[ST_MUL-1].it.rpx) * 64'(st[ST_MUL-1].wy);
    nxt[ST_MUL].mty = 64'(st[ST_MUL-1].it.rpy) * 64'(st[ST_MUL-1].wx);
  end

  always_comb begin
    nxt[ST_SUM]      = st[ST_SUM-1];
    nxt[ST_SUM].dot1 = st[ST_SUM-1].mdx + st[ST_SUM-1].mdy;
    nxt[ST_SUM].wls  = st[ST_SUM-1].mwx[62:0] + st[ST_SUM-1].mwy[62:0];
    nxt[ST_SUM].det  = st[ST_SUM-1].mtx - st[ST_SUM-1].mty;
  end

  always_comb begin
    nxt[ST_MAG]      = st[ST_MAG-1];
    nxt[ST_MAG].dneg = st[ST_MAG-1].dot1[63];
    nxt[ST_MAG].amag = st[ST_MAG-1].dot1[63] ? 64'(-st[ST_MAG-1].dot1)
                                             : 64'(st[ST_MAG-1].dot1);
  end

  // 32 x 32 partial products of dot^2 and R^2 * |w|^2
  always_comb begin
    nxt[ST_PART]      = st[ST_PART-1];
    nxt[ST_PART].a_ll = 64'(st[ST_PART-1].amag[31:0]) * 64'(st[ST_PART-1].amag[31:0]);
    nxt[ST_PART].a_lh = 64'(st[ST_PART-1].amag[31:0]) * 64'(st[ST_PART-1].amag[63:32]);
    nxt[ST_PART].a_hh = 64'(st[ST_PART-1].amag[63:32]) * 64'(st[ST_PART-1].amag[63:32]);
    nxt[ST_PART].c_ll = 64'(st[ST_PART-1].it.combsq[31:0]) * 64'(st[ST_PART-1].wls[31:0]);
    nxt[ST_PART].c_lh = 64'(st[ST_PART-1].it.combsq[31:0]) * 64'(st[ST_PART-1].wls[62:32]);
    nxt[ST_PART].c_hl = 64'(st[ST_PART-1].it.combsq[63:32]) * 64'(st[ST_PART-1].wls[31:0]);
    nxt[ST_PART].c_hh = 64'(st[ST_PART-1].it.combsq[63:32]) * 64'(st[ST_PART-1].wls[62:32]);
  end

  always_comb begin
    nxt[ST_WIDE]     = st[ST_WIDE-1];
    nxt[ST_WIDE].asq = 128'(st[ST_WIDE-1].a_ll) + (128'(st[ST_WIDE-1].a_lh) << 33)
                     + (128'(st[ST_WIDE-1].a_hh) << 64);
    nxt[ST_WIDE].cw  = 128'(st[ST_WIDE-1].c_ll) + (128'(st[ST_WIDE-1].c_lh) << 32)
                     + (128'(st[ST_WIDE-1].c_hl) << 32) + (128'(st[ST_WIDE-1].c_hh) << 64);
  end

  always_comb begin
    logic cut;
    nxt[ST_SEL] = st[ST_SEL-1];
    cut = !st[ST_SEL-1].it.apart
       || (st[ST_SEL-1].dneg && (st[ST_SEL-1].asq > st[ST_SEL-1].cw));
    nxt[ST_SEL].circ = cut;
    if (cut) begin
      nxt[ST_SEL].code = st[ST_SEL-1].it.apart ? CODE_CUTOFF : CODE_COLLIDE;
      nxt[ST_SEL].sq.n = {1'b0, st[ST_SEL-1].wls};
    end else begin
      nxt[ST_SEL].code = (st[ST_SEL-1].det > 64'sd0) ? CODE_LEFT : CODE_RIGHT;
      nxt[ST_SEL].sq.n = {1'b0, st[ST_SEL-1].it.distsq} - st[ST_SEL-1].it.combsq;
    end
    nxt[ST_SEL].sq.r = '0;
  end

  // integer square root, one result bit per step
  for (genvar j = 0; j < SQ_STG; j++) begin : g_sq
    always_comb begin
      sq_t v;
      v = st[ST_SQ0+j-1].sq;
      for (int i = 0; i < SQ_PER; i++) begin
        v = sq_step(v, 64'(1) << (62 - 2 * (SQ_PER * j + i)));
      end
      nxt[ST_SQ0+j]    = st[ST_SQ0+j-1];
      nxt[ST_SQ0+j].sq = v;
    end
  end

  always_comb begin
    logic signed [32:0] leg;
    logic signed [32:0] c;
    nxt[ST_NUM] = st[ST_NUM-1];
    leg = $signed({1'b0, st[ST_NUM-1].sq.r[31:0]});
    c   = $signed({1'b0, st[ST_NUM-1].it.comb});
    nxt[ST_NUM].pa   = 65'(st[ST_NUM-1].it.rpx) * 65'(leg);
    nxt[ST_NUM].pb   = 65'(st[ST_NUM-1].it.rpy) * 65'(c);
    nxt[ST_NUM].pc   = 65'(st[ST_NUM-1].it.rpy) * 65'(leg);
    nxt[ST_NUM].pd   = 65'(st[ST_NUM-1].it.rpx) * 65'(c);
    nxt[ST_NUM].pinv = 63'(st[ST_NUM-1].it.comb) * 63'(st[ST_NUM-1].inv);
  end

  always_comb begin
    logic signed [65:0] numx;
    logic signed [65:0] numy;
    logic flip;
    nxt[ST_ARG] = st[ST_ARG-1];
    flip = 1'b0;
    nxt[ST_ARG].s = 49'($signed({2'b0, st[ST_ARG-1].pinv[62:16]}))
                  - 49'($signed({1'b0, st[ST_ARG-1].sq.r[31:0]}));
    if (st[ST_ARG-1].circ) begin
      numx = 66'(st[ST_ARG-1].wx);
      numy = 66'(st[ST_ARG-1].wy);
      nxt[ST_ARG].den = {31'd0, st[ST_ARG-1].sq.r[31:0]};
      if (st[ST_ARG-1].sq.r[31:0] == 32'd0) begin
        nxt[ST_ARG].code = CODE_DEGEN;
      end
    end else if (st[ST_ARG-1].code == CODE_LEFT) begin
      numx = 66'(st[ST_ARG-1].pa) - 66'(st[ST_ARG-1].pb);
      numy = 66'(st[ST_ARG-1].pc) + 66'(st[ST_ARG-1].pd);
      nxt[ST_ARG].den = st[ST_ARG-1].it.distsq;
    end else begin
      numx = 66'(st[ST_ARG-1].pa) + 66'(st[ST_ARG-1].pb);
      numy = 66'(st[ST_ARG-1].pc) - 66'(st[ST_ARG-1].pd);
      nxt[ST_ARG].den = st[ST_ARG-1].it.distsq;
      flip = 1'b1;
    end
    nxt[ST_ARG].sgx  = numx[65] ^ flip;
    nxt[ST_ARG].sgy  = numy[65] ^ flip;
    nxt[ST_ARG].magx = numx[65] ? 66'(-numx) : 66'(numx);
    nxt[ST_ARG].magy = numy[65] ? 66'(-numy) : 66'(numy);
  end

  // restoring divide to Q1.16
  for (genvar j = 0; j < DV_STG; j++) begin : g_dv
    always_comb begin
      dv_t ax;
      dv_t ay;
      nxt[ST_DV0+j] = st[ST_DV0+j-1];
      if (j == 0) begin
        nxt[ST_DV0+j].bigx = st[ST_DV0+j-1].magx >= {3'd0, st[ST_DV0+j-1].den};
        nxt[ST_DV0+j].bigy = st[ST_DV0+j-1].magy >= {3'd0, st[ST_DV0+j-1].den};
        ax.r = st[ST_DV0+j-1].magx[63:0];
        ay.r = st[ST_DV0+j-1].magy[63:0];
        ax.q = '0;
        ay.q = '0;
      end else begin
        ax = st[ST_DV0+j-1].dvx;
        ay = st[ST_DV0+j-1].dvy;
      end
      for (int i = 0; i < DV_PER; i++) begin
        ax = dv_step(ax, st[ST_DV0+j-1].den);
        ay = dv_step(ay, st[ST_DV0+j-1].den);
      end
      nxt[ST_DV0+j].dvx = ax;
      nxt[ST_DV0+j].dvy = ay;
    end
  end

  always_comb begin
    logic signed [17:0] qx;
    logic signed [17:0] qy;
    nxt[ST_DIR] = st[ST_DIR-1];
    qx = st[ST_DIR-1].bigx ? 18'sd65536 : $signed({2'b0, st[ST_DIR-1].dvx.q});
    qy = st[ST_DIR-1].bigy ? 18'sd65536 : $signed({2'b0, st[ST_DIR-1].dvy.q});
    if (st[ST_DIR-1].sgx) begin
      qx = -qx;
    end
    if (st[ST_DIR-1].sgy) begin
      qy = -qy;
    end
    nxt[ST_DIR].nxq = qx;
    nxt[ST_DIR].nyq = qy;
    if (st[ST_DIR-1].circ) begin
      nxt[ST_DIR].dx = qy;
      nxt[ST_DIR].dy = -qx;
    end else begin
      nxt[ST_DIR].dx = qx;
      nxt[ST_DIR].dy = qy;
    end
  end

  always_comb begin
    nxt[ST_P1] = st[ST_P1-1];
    if (st[ST_P1-1].circ) begin
      nxt[ST_P1].px = 67'(st[ST_P1-1].nxq) * 67'(st[ST_P1-1].s);
      nxt[ST_P1].py = 67'(st[ST_P1-1].nyq) * 67'(st[ST_P1-1].s);
    end else begin
      nxt[ST_P1].px = 67'(st[ST_P1-1].it.rvx) * 67'(st[ST_P1-1].dx);
      nxt[ST_P1].py = 67'(st[ST_P1-1].it.rvy) * 67'(st[ST_P1-1].dy);
    end
  end

  always_comb begin
    logic signed [66:0] acc;
    nxt[ST_P2] = st[ST_P2-1];
    acc = st[ST_P2-1].px + st[ST_P2-1].py;
    nxt[ST_P2].ux   = 51'(st[ST_P2-1].px >>> 16);
    nxt[ST_P2].uy   = 51'(st[ST_P2-1].py >>> 16);
    nxt[ST_P2].dot2 = 36'(acc >>> 16);
  end

  always_comb begin
    nxt[ST_P3]    = st[ST_P3-1];
    nxt[ST_P3].mx = 54'(st[ST_P3-1].dx) * 54'(st[ST_P3-1].dot2);
    nxt[ST_P3].my = 54'(st[ST_P3-1].dy) * 54'(st[ST_P3-1].dot2);
  end

  always_comb begin
    nxt[ST_P4] = st[ST_P4-1];
    if (!st[ST_P4-1].circ) begin
      nxt[ST_P4].ux = 51'(st[ST_P4-1].mx >>> 16) - 51'(st[ST_P4-1].it.rvx);
      nxt[ST_P4].uy = 51'(st[ST_P4-1].my >>> 16) - 51'(st[ST_P4-1].it.rvy);
    end
  end

  always_comb begin
    logic signed [50:0] ux;
    logic signed [50:0] uy;
    nxt[ST_OUT] = st[ST_OUT-1];
    ux = st[ST_OUT-1].ux;
    uy = st[ST_OUT-1].uy;
    if (st[ST_OUT-1].code == CODE_DEGEN) begin
      nxt[ST_OUT].dx = '0;
      nxt[ST_OUT].dy = '0;
      ux = '0;
      uy = '0;
    end
    nxt[ST_OUT].ptx = sat32(52'(st[ST_OUT-1].it.ovx) + 52'(ux >>> 1));
    nxt[ST_OUT].pty = sat32(52'(st[ST_OUT-1].it.ovy) + 52'(uy >>> 1));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < NST; k++) begin
        st[k] <= nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[NST-2:0], head_valid};
    end
  end

  assign out_valid = vld[NST-1];
  assign dir_x     = st[ST_OUT].dx;
  assign dir_y     = st[ST_OUT].dy;
  assign point_x   = st[ST_OUT].ptx;
  assign point_y   = st[ST_OUT].pty;
  assign case_code = st[ST_OUT].code;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import ocl_pkg::*;

  localparam longint ONE = 65536;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [2:0]         case_code;
  } line_t;

  typedef logic signed [127:0] wide_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_INV_TH;
  logic [30:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [319:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic [2:0] m_tuser;

  logic [30:0] inv_th_copy = INV_RESET;
  logic [30:0] inv_ts_copy = INV_RESET;
  line_t lines_due[$];
  int errors = 0;
  int checked = 0;
  int case_seen[5];
  int quiet_cycles = 0;
  bit no_idle = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_off_done = 1'b0;

  orca_constraint_line dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #1 clk = ~clk;

  function automatic wide_t clip_sym(wide_t x);
    if (x > 128'sd2147483647) begin
      return 128'sd2147483647;
    end
    if (x < -128'sd2147483647) begin
      return -128'sd2147483647;
    end
    return x;
  endfunction

  function automatic wide_t root_floor(wide_t n_in);
    logic [63:0] n, res, b;
    n = n_in[63:0];
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return $signed({64'd0, res});
  endfunction

  function automatic wide_t unit_comp(wide_t num, wide_t den);
    wide_t n, q;
    n = (num < 0) ? -num : num;
    if (n >= den) begin
      q = ONE;
    end else begin
      q = (n <<< 16) / den;
    end
    return (num < 0) ? -q : q;
  endfunction

  function automatic bit circle_proj(wide_t wx, wide_t wy, wide_t comb, wide_t inv,
                                     output wide_t dx, output wide_t dy,
                                     output wide_t ux, output wide_t uy);
    wide_t wl, nx, ny, s;
    wl = root_floor(wx * wx + wy * wy);
    dx = 0; dy = 0; ux = 0; uy = 0;
    if (wl == 0) begin
      return 1'b0;
    end
    nx = unit_comp(wx, wl);
    ny = unit_comp(wy, wl);
    dx = ny;
    dy = -nx;
    s = ((comb * inv) >>> 16) - wl;
    ux = (nx * s) >>> 16;
    uy = (ny * s) >>> 16;
    return 1'b1;
  endfunction

  function automatic line_t predict_line(pair_t p);
    wide_t opx, opy, ovx, ovy, npx, npy, nvx, nvy;
    wide_t rpx, rpy, rvx, rvy, comb, combsq, distsq, inv, wx, wy, dot1, wls;
    wide_t dx, dy, ux, uy, leg, dot2, px, py;
    logic [2:0] code;
    bit cut;
    line_t r;
    opx = p.own_pos_x; opy = p.own_pos_y; ovx = p.own_vel_x; ovy = p.own_vel_y;
    npx = p.nbr_pos_x; npy = p.nbr_pos_y; nvx = p.nbr_vel_x; nvy = p.nbr_vel_y;
    rpx = clip_sym(npx - opx); rpy = clip_sym(npy - opy);
    rvx = clip_sym(ovx - nvx); rvy = clip_sym(ovy - nvy);
    comb = p.own_reach;
    comb = comb + p.nbr_reach;
    combsq = comb * comb;
    distsq = rpx * rpx + rpy * rpy;
    dx = 0; dy = 0; ux = 0; uy = 0;
    inv = (distsq > combsq) ? inv_th_copy : inv_ts_copy;
    wx = clip_sym(rvx - ((rpx * inv) >>> 16));
    wy = clip_sym(rvy - ((rpy * inv) >>> 16));
    if (distsq > combsq) begin
      dot1 = wx * rpx + wy * rpy;
      wls = wx * wx + wy * wy;
      cut = (dot1 < 0) && (dot1 * dot1 > combsq * wls);
      if (cut) begin
        code = circle_proj(wx, wy, comb, inv, dx, dy, ux, uy) ? CODE_CUTOFF : CODE_DEGEN;
      end else begin
        leg = root_floor(distsq - combsq);
        if (rpx * wy - rpy * wx > 0) begin
          dx = unit_comp(rpx * leg - rpy * comb, distsq);
          dy = unit_comp(rpy * leg + rpx * comb, distsq);
          code = CODE_LEFT;
        end else begin
          dx = -unit_comp(rpx * leg + rpy * comb, distsq);
          dy = -unit_comp(rpy * leg - rpx * comb, distsq);
          code = CODE_RIGHT;
        end
        dot2 = (rvx * dx + rvy * dy) >>> 16;
        ux = ((dx * dot2) >>> 16) - rvx;
        uy = ((dy * dot2) >>> 16) - rvy;
      end
    end else begin
      code = circle_proj(wx, wy, comb, inv, dx, dy, ux, uy) ? CODE_COLLIDE : CODE_DEGEN;
    end
    if (code == CODE_DEGEN) begin
      dx = 0; dy = 0; ux = 0; uy = 0;
    end
    px = ovx + (ux >>> 1);
    py = ovy + (uy >>> 1);
    if (px > 128'sd2147483647) px = 128'sd2147483647;
    if (px < -128'sd2147483648) px = -128'sd2147483648;
    if (py > 128'sd2147483647) py = 128'sd2147483647;
    if (py < -128'sd2147483648) py = -128'sd2147483648;
    r.dir_x = dx[17:0];
    r.dir_y = dy[17:0];
    r.point_x = px[31:0];
    r.point_y = py[31:0];
    r.case_code = code;
    return r;
  endfunction

  // receiver side: random stall bursts, plus a long hold-off on request
  always @(negedge clk) begin
    int gap;
    if (hold_off_req && !hold_off_done) begin
      m_tready <= 1'b0;
      repeat (300) @(negedge clk);
      hold_off_done = 1'b1;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      m_tready <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    line_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.dir_x = m_tdata[17:0];
      got.dir_y = m_tdata[35:18];
      got.point_x = m_tdata[67:36];
      got.point_y = m_tdata[99:68];
      got.case_code = m_tuser;
      if (lines_due.size() == 0) begin
        $display("%0t: unexpected word %h case %0d", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want = lines_due.pop_front();
        checked++;
        if (want.case_code <= CODE_DEGEN) case_seen[want.case_code]++;
        if (got.dir_x !== want.dir_x) begin
          $display("%0t: dir_x expected %0d got %0d", $time, want.dir_x, got.dir_x);
          errors++;
        end
        if (got.dir_y !== want.dir_y) begin
          $display("%0t: dir_y expected %0d got %0d", $time, want.dir_y, got.dir_y);
          errors++;
        end
        if (got.point_x !== want.point_x) begin
          $display("%0t: point_x expected %0d got %0d", $time, want.point_x, got.point_x);
          errors++;
        end
        if (got.point_y !== want.point_y) begin
          $display("%0t: point_y expected %0d got %0d", $time, want.point_y, got.point_y);
          errors++;
        end
        if (got.case_code !== want.case_code) begin
          $display("%0t: case_code expected %0d got %0d", $time, want.case_code,
                   got.case_code);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d words outstanding", $time, lines_due.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_pair(pair_t p, bit allow_gap);
    int gap;
    if (allow_gap && !no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, p.nbr_reach, p.nbr_vel_y, p.nbr_vel_x, p.nbr_pos_y, p.nbr_pos_x,
                p.own_reach, p.own_vel_y, p.own_vel_x, p.own_pos_y, p.own_pos_x};
    do @(posedge clk); while (!s_tready);
    lines_due.insert(lines_due.size(), predict_line(p));
    @(negedge clk);
  endtask

  task automatic idle_sender();
    s_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    idle_sender();
    while (lines_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_INV_TH) inv_th_copy = val;
    else inv_ts_copy = val;
    @(negedge clk);
  endtask

  function automatic pair_t mk(longint opx, longint opy, longint ovx, longint ovy,
                               longint ore, longint npx, longint npy, longint nvx,
                               longint nvy, longint nre);
    pair_t p;
    p.own_pos_x = 32'(opx); p.own_pos_y = 32'(opy);
    p.own_vel_x = 32'(ovx); p.own_vel_y = 32'(ovy);
    p.own_reach = 31'(ore); p.nbr_pos_x = 32'(npx);
    p.nbr_pos_y = 32'(npy); p.nbr_vel_x = 32'(nvx);
    p.nbr_vel_y = 32'(nvy); p.nbr_reach = 31'(nre);
    return p;
  endfunction

  function automatic logic [31:0] rand_near(logic [31:0] base, int span_bits);
    logic [31:0] d;
    d = $urandom();
    d = d & ((32'd1 << span_bits) - 1);
    return $urandom_range(0, 1) ? base + d : base - d;
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int kind, sb;
    kind = $urandom_range(0, 9);
    sb = $urandom_range(12, 24);
    p.own_pos_x = $urandom(); p.own_pos_y = $urandom();
    p.own_vel_x = $urandom(); p.own_vel_y = $urandom();
    p.nbr_pos_x = $urandom(); p.nbr_pos_y = $urandom();
    p.nbr_vel_x = $urandom(); p.nbr_vel_y = $urandom();
    p.own_reach = 31'($urandom()); p.nbr_reach = 31'($urandom());
    if (kind < 8) begin
      // nearby agents with moderate speeds, reach about the spacing
      p.nbr_pos_x = rand_near(p.own_pos_x, sb);
      p.nbr_pos_y = rand_near(p.own_pos_y, sb);
      p.own_vel_x = rand_near(32'd0, sb);
      p.own_vel_y = rand_near(32'd0, sb);
      p.nbr_vel_x = rand_near(32'd0, sb);
      p.nbr_vel_y = rand_near(32'd0, sb);
      p.own_reach = 31'($urandom() & ((32'd1 << (sb - $urandom_range(0, 2))) - 1));
      p.nbr_reach = 31'($urandom() & ((32'd1 << (sb - $urandom_range(0, 2))) - 1));
    end else if (kind == 8) begin
      p.own_reach = 31'({1'b0, p.own_reach} & ((32'd1 << sb) - 1));
      p.nbr_reach = 31'({1'b0, p.nbr_reach} & ((32'd1 << sb) - 1));
    end
    return p;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_pair(rand_pair(), 1'b1);
  endtask

  task automatic test_directed();
    longint mx, mn, rmx;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    rmx = 64'sd2147483647;
    // both agents at the same spot at rest: w vanishes
    send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    send_pair(mk(0, 0, 0, 0, ONE, ONE, 0, 0, 0, ONE), 1'b0);
    // exact contact counts as overlapping
    send_pair(mk(0, 0, 0, 0, ONE, 2 * ONE, 0, 0, 0, ONE), 1'b0);
    send_pair(mk(0, 0, 0, 0, ONE, 10 * ONE, 0, 0, 0, ONE), 1'b0);
    send_pair(mk(0, 0, 20 * ONE, 3 * ONE, ONE, 10 * ONE, 0, 0, 0, ONE), 1'b0);
    send_pair(mk(0, 0, 20 * ONE, -3 * ONE, ONE, 10 * ONE, 0, 0, 0, ONE), 1'b0);
    // collinear w and rp: left/right tie
    send_pair(mk(0, 0, 20 * ONE, 0, ONE, 10 * ONE, 0, 0, 0, ONE), 1'b0);
    send_pair(mk(5 * ONE, -7 * ONE, ONE, 2 * ONE, ONE / 2, -3 * ONE, 4 * ONE, -ONE, 0,
                 ONE / 4), 1'b0);
    // saturating differences
    send_pair(mk(mx, mx, mx, mx, rmx, mn, mn, mn, mn, rmx), 1'b0);
    send_pair(mk(mn, mn, mn, mn, 0, mx, mx, mx, mx, 0), 1'b0);
    send_pair(mk(mx, mn, mn, mx, 0, mn, mx, mx, mn, 0), 1'b0);
    send_pair(mk(mn, mx, mx, mn, rmx, mx, mn, mn, mx, 0), 1'b0);
    send_pair(mk(mx, mx, mx, mx, 0, mx, mx, mx, mx, rmx), 1'b0);
    send_pair(mk(-1, -1, -1, -1, 1, 0, 0, 0, 0, 0), 1'b0);
    send_pair(mk(0, 0, mx, mn, 0, ONE, ONE, mn, mx, 0), 1'b0);
    send_pair(mk(0, 0, -20 * ONE, 0, ONE, 10 * ONE, 0, 0, 0, ONE), 1'b0);
    send_pair(mk(0, 0, 0, 20 * ONE, ONE, 0, 10 * ONE, 0, 0, ONE), 1'b0);
    wait_drained();
  endtask

  task automatic test_register_sweep();
    write_reg(REG_INV_TH, 31'd0);
    write_reg(REG_INV_TS, 31'd0);
    run_random(200);
    wait_drained();
    write_reg(REG_INV_TH, 31'h7fffffff);
    write_reg(REG_INV_TS, 31'h7fffffff);
    run_random(200);
    wait_drained();
    write_reg(REG_INV_TH, 31'd1);
    write_reg(REG_INV_TS, 31'd4 * 31'd65536);
    run_random(200);
    wait_drained();
    write_reg(REG_INV_TH, 31'($urandom_range(0, 32'h7fffffff)));
    write_reg(REG_INV_TS, 31'($urandom_range(0, 32'h7fffffff)));
    run_random(200);
    wait_drained();
    write_reg(REG_INV_TH, 31'($urandom_range(ONE / 16, 2 * ONE)));
    write_reg(REG_INV_TS, 31'($urandom_range(ONE, 16 * ONE)));
    run_random(200);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off_req = 1'b1;
    repeat (60) send_pair(rand_pair(), 1'b0);
    idle_sender();
    while (!hold_off_done) @(negedge clk);
    hold_off_req = 1'b0;
    wait_drained();
  endtask

  task automatic test_sender_pause();
    repeat (4) begin
      run_random(10);
      idle_sender();
      while (lines_due.size() != 0) @(negedge clk);
    end
  endtask

  task automatic test_steady_flow();
    write_reg(REG_INV_TH, INV_RESET);
    write_reg(REG_INV_TS, INV_RESET);
    no_idle = 1'b1;
    run_random(250);
    idle_sender();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_register_sweep();
    test_backpressure();
    test_sender_pause();
    test_steady_flow();
    while (lines_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("checked %0d lines: cutoff %0d, left %0d, right %0d, collide %0d, degen %0d",
             checked, case_seen[CODE_CUTOFF], case_seen[CODE_LEFT], case_seen[CODE_RIGHT],
             case_seen[CODE_COLLIDE], case_seen[CODE_DEGEN]);
    $display("covered register extremes, output hold-off and sender pauses");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/ocl_pkg.sv
hdl/ocl_fifo.sv
hdl/ocl_front.sv
hdl/ocl_back.sv
hdl/orca_constraint_line.sv
sim/tb_top.sv
